@@ rtl/sitpd_pkg.sv @@
// Shared types and constants for the signed integer to padded decimal text block.
// Used by the back and top level modules and by the testbench; depends on nothing else.
package sitpd_pkg;

	localparam int FIELD_WIDTH_BITS = 6;
	localparam int CHAR_BITS        = 8;
	localparam int BCD_BITS         = 4;
	localparam int DABBLE_STEPS     = 4;

	localparam logic [CHAR_BITS-1:0] CHAR_BLANK = 8'h20;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

	localparam logic [BCD_BITS-1:0] BCD_ADJ_LIMIT = 4'd5;
	localparam logic [BCD_BITS-1:0] BCD_ADJ_ADD   = 4'd3;

	typedef enum logic [1:0] {
		BACK_IDLE,
		BACK_CONV,
		BACK_COUNT,
		BACK_EMIT
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic emitting;
	} back_status_t;

endpackage

@@ rtl/sitpd_fifo.sv @@
// Two-entry queue between the front and the back of the decimal text block.
// Standalone; carries a flat payload of WIDTH bits.
module sitpd_fifo #(
	parameter int WIDTH = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [1:0][WIDTH-1:0] entry_q;
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/sitpd_front.sv @@
// Front of the decimal text block: accepts input beats and splits them into
// sign and unsigned magnitude for the queue. No package dependencies.
module sitpd_front #(
	parameter int VALUE_BITS = 32
) (
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         value_valid,
	output logic                         value_ready,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [VALUE_BITS:0]          push_data
);

	logic                  negative;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] magnitude;

	assign raw         = value;
	assign negative    = raw[VALUE_BITS-1];
	assign magnitude   = negative ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
	assign push_valid  = value_valid;
	assign value_ready = push_ready;
	assign push_data   = {negative, magnitude};

endmodule

@@ rtl/sitpd_back.sv @@
// Back of the decimal text block: converts a queued magnitude to BCD with a
// shift-and-add-3 loop, then emits padding, sign and digits. Uses sitpd_pkg.
module sitpd_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pop_valid,
	output logic                                  pop_ready,
	input  logic [VALUE_BITS:0]                   pop_data,
	input  logic [sitpd_pkg::FIELD_WIDTH_BITS-1:0] field_width,
	output logic [sitpd_pkg::CHAR_BITS-1:0]        char_out,
	output logic                                  last,
	output logic                                  char_valid,
	input  logic                                  char_ready,
	output sitpd_pkg::back_status_t               status
);
	import sitpd_pkg::*;

	localparam int NDIG        = (VALUE_BITS * 31) / 100 + 1;
	localparam int NDIG_W      = $clog2(NDIG + 1);
	localparam int IDX_W       = $clog2(NDIG);
	localparam int SHIFT_W     = ((VALUE_BITS + DABBLE_STEPS - 1) / DABBLE_STEPS) * DABBLE_STEPS;
	localparam int CONV_CYCLES = SHIFT_W / DABBLE_STEPS;
	localparam int CNT_W       = $clog2(CONV_CYCLES + 1);

	back_state_t                        state_q;
	back_state_t                        state_n;
	logic                               neg_q;
	logic [SHIFT_W-1:0]                 shift_q;
	logic [SHIFT_W-1:0]                 shift_n;
	logic [NDIG-1:0][BCD_BITS-1:0]      bcd_q;
	logic [NDIG-1:0][BCD_BITS-1:0]      bcd_n;
	logic [CNT_W-1:0]                   cnt_q;
	logic [NDIG_W-1:0]                  ndig_q;
	logic [NDIG_W-1:0]                  ndig;
	logic [FIELD_WIDTH_BITS-1:0]        text_q;
	logic [FIELD_WIDTH_BITS-1:0]        text_len;
	logic [FIELD_WIDTH_BITS-1:0]        total;
	logic [FIELD_WIDTH_BITS-1:0]        rem_q;
	logic [CHAR_BITS-1:0]               ch;
	logic [CHAR_BITS-1:0]               char_q;
	logic                               last_q;
	logic                               valid_q;
	logic                               out_load;
	logic                               do_pop;

	assign pop_ready       = (state_q == BACK_IDLE);
	assign do_pop          = pop_valid && pop_ready;
	assign out_load        = (state_q == BACK_EMIT) && (!valid_q || char_ready);
	assign char_out        = char_q;
	assign last            = last_q;
	assign char_valid      = valid_q;
	assign status.busy     = (state_q != BACK_IDLE);
	assign status.emitting = (state_q == BACK_EMIT);

	always_comb begin
		bcd_n   = bcd_q;
		shift_n = shift_q;
		for (int st = 0; st < DABBLE_STEPS; st++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d] >= BCD_ADJ_LIMIT) begin
					bcd_n[d] = bcd_n[d] + BCD_ADJ_ADD;
				end
			end
			{bcd_n, shift_n} = {bcd_n, shift_n} << 1;
		end
	end

	always_comb begin
		ndig = NDIG_W'(1);
		for (int d = 1; d < NDIG; d++) begin
			if (bcd_q[d] != '0) begin
				ndig = NDIG_W'(d + 1);
			end
		end
	end

	assign text_len = FIELD_WIDTH_BITS'(ndig) + FIELD_WIDTH_BITS'(neg_q);
	assign total    = (field_width > text_len) ? field_width : text_len;

	always_comb begin
		if (rem_q >= text_q) begin
			ch = CHAR_BLANK;
		end else if (neg_q && rem_q == FIELD_WIDTH_BITS'(ndig_q)) begin
			ch = CHAR_MINUS;
		end else begin
			ch = CHAR_ZERO + {{(CHAR_BITS-BCD_BITS){1'b0}}, bcd_q[rem_q[IDX_W-1:0]]};
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BACK_IDLE: begin
				if (do_pop) begin
					state_n = BACK_CONV;
				end
			end
			BACK_CONV: begin
				if (cnt_q == CNT_W'(CONV_CYCLES - 1)) begin
					state_n = BACK_COUNT;
				end
			end
			BACK_COUNT: begin
				state_n = BACK_EMIT;
			end
			BACK_EMIT: begin
				if (out_load && rem_q == '0) begin
					state_n = BACK_IDLE;
				end
			end
			default: begin
				state_n = BACK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BACK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (char_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			neg_q   <= pop_data[VALUE_BITS];
			shift_q <= SHIFT_W'(pop_data[VALUE_BITS-1:0]);
			bcd_q   <= '0;
			cnt_q   <= '0;
		end else if (state_q == BACK_CONV) begin
			shift_q <= shift_n;
			bcd_q   <= bcd_n;
			cnt_q   <= cnt_q + CNT_W'(1);
		end
		if (state_q == BACK_COUNT) begin
			ndig_q <= ndig;
			text_q <= text_len;
			rem_q  <= total - FIELD_WIDTH_BITS'(1);
		end else if (out_load) begin
			rem_q <= rem_q - FIELD_WIDTH_BITS'(1);
		end
		if (out_load) begin
			char_q <= ch;
			last_q <= (rem_q == '0);
		end
	end

endmodule

@@ rtl/signed_int_to_padded_decimal.sv @@
// Top level of the signed integer to right-justified decimal text converter.
// Instantiates sitpd_front, sitpd_fifo and sitpd_back; uses sitpd_pkg.
//
// Usage:
// Each beat on the value channel carries one two's complement integer of
// VALUE_BITS bits. The block answers with a run of character beats on the
// char channel, most significant first: blanks up to the minimum field width,
// a minus sign for negative values, then the digits. The last beat of a run
// has last set. The field_width register is written over the cfg channel,
// which is always ready, and should only change while no run is in flight.
// The back picks up an item from the queue, runs the shift-and-add-3
// conversion at four bits per cycle, counts the digits, then emits the
// characters one by one as the receiver takes them.
// A two-entry queue sits between front and back, so up to two further values
// are accepted while a run is being converted or emitted.
// Reset clears the queue, the back state machine, the output register and
// sets field_width to zero. A stalled receiver holds the current character;
// the back waits, and value_ready drops once the queue is full.
module signed_int_to_padded_decimal #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [VALUE_BITS-1:0]           value,
	input  logic                                   value_valid,
	output logic                                   value_ready,
	output logic [sitpd_pkg::CHAR_BITS-1:0]         char_out,
	output logic                                   last,
	output logic                                   char_valid,
	input  logic                                   char_ready,
	input  logic [sitpd_pkg::FIELD_WIDTH_BITS-1:0]  field_width,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready
);
	import sitpd_pkg::*;

	logic [FIELD_WIDTH_BITS-1:0] field_width_q;
	logic                        push_valid;
	logic                        push_ready;
	logic [VALUE_BITS:0]         push_data;
	logic                        pop_valid;
	logic                        pop_ready;
	logic [VALUE_BITS:0]         pop_data;
	back_status_t                back_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			field_width_q <= field_width;
		end
	end

	sitpd_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.value      (value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sitpd_fifo #(
		.WIDTH(VALUE_BITS + 1)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	sitpd_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.field_width(field_width_q),
		.char_out   (char_out),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.status     (back_status)
	);

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_out == CHAR_BLANK || char_out == CHAR_MINUS ||
			(char_out >= CHAR_ZERO && char_out <= CHAR_NINE)))
		else $error("character outside blank, minus and digits");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && last |-> (char_out >= CHAR_ZERO && char_out <= CHAR_NINE))
		else $error("run does not end on a digit");

	a_full_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!value_ready && !back_status.busy |=> back_status.busy)
		else $error("queue full and the back did not pick up an item");

	a_valid_only_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_valid) |-> $past(back_status.emitting))
		else $error("character beat raised outside emission");

endmodule

@@ test/sitpd_checker.sv @@
// Checker for signed_int_to_padded_decimal: watches the value, char and cfg channels,
// predicts each run of character beats and compares it with what the block sends.
// Uses sitpd_pkg for the character codes and the register width.
module sitpd_checker #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [VALUE_BITS-1:0]          value,
	input  logic                                  value_valid,
	input  logic                                  value_ready,
	input  logic [sitpd_pkg::CHAR_BITS-1:0]        char_out,
	input  logic                                  last,
	input  logic                                  char_valid,
	input  logic                                  char_ready,
	input  logic [sitpd_pkg::FIELD_WIDTH_BITS-1:0] field_width,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	output int                                    pending,
	output int                                    failures
);
	timeunit 1ns;
	timeprecision 1ps;

	import sitpd_pkg::*;

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 is_last;
	} char_beat_t;

	char_beat_t                  expected_chars[$];
	char_beat_t                  want;
	logic [FIELD_WIDTH_BITS-1:0] cur_width;

	task automatic report_mismatch(input string what);
		failures++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic predict_text(input logic [VALUE_BITS-1:0] raw,
			input logic [FIELD_WIDTH_BITS-1:0] width);
		logic [VALUE_BITS-1:0] mag;
		logic [3:0]            digit[0:19];
		int                    ndig;
		int                    text_len;
		int                    total;
		bit                    neg;
		neg = raw[VALUE_BITS-1];
		mag = neg ? (~raw + 1'b1) : raw;
		ndig = 0;
		do begin
			digit[ndig] = 4'(mag % 10);
			ndig++;
			mag = mag / 10;
		end while (mag != 0);
		text_len = ndig + (neg ? 1 : 0);
		total = (int'(width) > text_len) ? int'(width) : text_len;
		for (int i = 0; i < total - text_len; i++) begin
			expected_chars.push_back('{CHAR_BLANK, 1'b0});
		end
		if (neg) begin
			expected_chars.push_back('{CHAR_MINUS, 1'b0});
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			expected_chars.push_back('{CHAR_ZERO + CHAR_BITS'(digit[i]), i == 0});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			cur_width = '0;
			pending <= 0;
		end else begin
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character beat 0x%02h with nothing expected",
						char_out));
				end else begin
					want = expected_chars.pop_front();
					if (char_out !== want.ch) begin
						report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
							char_out, want.ch));
					end
					if (last !== want.is_last) begin
						report_mismatch($sformatf("last %b, expected %b on char 0x%02h",
							last, want.is_last, want.ch));
					end
				end
			end
			if (value_valid && value_ready) begin
				predict_text(value, cur_width);
			end
			if (cfg_valid && cfg_ready) begin
				cur_width = field_width;
			end
			pending <= expected_chars.size();
		end
	end

endmodule

@@ test/tb.sv @@
// Testbench top for signed_int_to_padded_decimal: drives values and field widths,
// stalls the character channel at random and gives the verdict.
// Depends on sitpd_pkg, the block itself and sitpd_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sitpd_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 50;

	logic                        clk;
	logic                        arst_n;
	logic signed [VALUE_BITS-1:0] value;
	logic                        value_valid;
	logic                        value_ready;
	logic [CHAR_BITS-1:0]        char_out;
	logic                        last;
	logic                        char_valid;
	logic                        char_ready;
	logic [FIELD_WIDTH_BITS-1:0] field_width;
	logic                        cfg_valid;
	logic                        cfg_ready;
	int                          pending;
	int                          failures;
	int                          cycles;
	bit                          steady;

	signed_int_to_padded_decimal #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.char_out(char_out),
		.last(last),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.field_width(field_width),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	sitpd_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.value_valid(value_valid),
		.value_ready(value_ready),
		.char_out(char_out),
		.last(last),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.field_width(field_width),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.pending(pending),
		.failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int stall;
		char_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk);
				char_ready <= 1'b0;
			end
			@(negedge clk);
			char_ready <= 1'b1;
			do @(posedge clk); while (!(char_valid && char_ready));
		end
	end

	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [VALUE_BITS-1:0] v;
		logic [VALUE_BITS-1:0] p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = VALUE_BITS'($signed($urandom_range(0, 2000)) - 1000);
			6: begin
				p = 1;
				repeat ($urandom_range(0, 9)) p = p * 10;
				v = p + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1)) v = -v;
			end
			7: begin
				case ($urandom_range(0, 4))
					0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
					1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
					2: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
					3: v = '0;
					default: v = '1;
				endcase
			end
			default: begin
				v = $urandom_range(0, 99999);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			value_valid <= 1'b0;
		end
		@(negedge clk);
		value <= v;
		value_valid <= 1'b1;
		do @(posedge clk); while (!value_ready);
	endtask

	// The sender holds off until every predicted beat has arrived.
	task automatic wait_drained();
		@(negedge clk);
		value_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_width(input logic [FIELD_WIDTH_BITS-1:0] w);
		wait_drained();
		field_width <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [VALUE_BITS-1:0] opening[] = '{
			32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, 32'd99, -32'sd100,
			32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'd1000000000,
			32'h55555555, 32'hAAAAAAAA
		};
		logic [FIELD_WIDTH_BITS-1:0] w;

		arst_n = 1'b0;
		value = '0;
		value_valid = 1'b0;
		field_width = '0;
		cfg_valid = 1'b0;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening[i]) send_value(opening[i]);
		write_width(6'd11);
		send_value(32'h80000000);
		send_value(32'h7FFFFFFF);
		send_value(32'd0);
		write_width(6'd63);
		send_value(32'h80000000);
		send_value(32'd7);
		write_width(6'd1);
		send_value(32'd0);
		send_value(-32'sd5);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: w = 6'd0;
				1: w = 6'd63;
				2: w = 6'd1;
				3: w = 6'd10;
				default: w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 14));
			endcase
			write_width(w);
			steady = (ph % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) wait_drained();
				send_value(random_value());
			end
		end
		steady = 1'b0;
		wait_drained();

		if (failures == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
